>>> rtl/dvru_pkg.sv
// Shared types and constants of the distance-vector route update block.
// Used by dvru_update and by the top level; depends on nothing.
package dvru_pkg;

    localparam int NODE_COUNT = 64;
    localparam int ID_W       = $clog2(NODE_COUNT);
    localparam int DIST_BITS  = 16;
    localparam int COST_W     = DIST_BITS + 1;
    localparam int ROUTE_W    = DIST_BITS + ID_W;
    localparam int CNT_W      = $clog2(NODE_COUNT + 1);

    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    localparam logic REQ_LINK = 1'b0;
    localparam logic REQ_ADV  = 1'b1;

    localparam logic STATUS_APPLIED = 1'b0;
    localparam logic STATUS_IGNORED = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_PURGE = 3'b100
    } state_t;

    // One accepted request.
    typedef struct packed {
        logic                    req_type;
        logic [ID_W-1:0]         neighbor_id;
        logic [ID_W-1:0]         dest_id;
        logic signed [COST_W-1:0] link_cost;
        logic [DIST_BITS-1:0]    adv_dist;
        logic [ID_W-1:0]         adv_next_hop;
        logic                    last_entry;
    } item_t;

    // Decision for one request: table writes and the result fields.
    typedef struct packed {
        logic                 status;
        logic                 entry_changed;
        logic                 route_valid;
        logic [DIST_BITS-1:0] route_dist;
        logic [ID_W-1:0]      route_next_hop;
        logic                 row_changed;
        logic                 route_we;
        logic                 link_we;
        logic                 link_remove;
        logic                 row_dirty_next;
    } upd_t;

endpackage

>>> rtl/distance_vector_route_update_top.sv
// Distance-vector routing table of one router with poisoned reverse.
// A request is accepted in ST_IDLE; its result is registered from ST_EXEC, which waits
// while the output still holds an unaccepted result.
// No new request is accepted until ST_EXEC is done (memory read, then modify and write).
// A link removal then sweeps all NODE_COUNT route memory entries in ST_PURGE.
// Reset (aresetn low, synchronous) clears the route and link valid bits and the
// row-changed flag; the memories are not cleared.
module distance_vector_route_update_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata,   // own_node
    input  logic        s_tvalid,
    output logic        s_tready,
    // neighbor_id[5:0], dest_id[11:6], link_cost[28:12], adv_dist[44:29],
    // adv_next_hop[50:45], zero padding[55:51]
    input  logic [55:0] s_tdata,
    input  logic        s_tuser,     // req_type
    input  logic        s_tlast,     // last_entry
    output logic        m_tvalid,
    input  logic        m_tready,
    // entry_changed[0], route_valid[1], route_dist[17:2], route_next_hop[23:18],
    // row_changed[24], zero padding[31:25]
    output logic [31:0] m_tdata,
    output logic        m_tuser      // status
);

    localparam int ID_W = dvru_pkg::ID_W;

    dvru_pkg::state_t state_reg, state_next;
    dvru_pkg::item_t  item_reg;
    dvru_pkg::item_t  s_item;
    dvru_pkg::upd_t   upd;

    logic [ID_W-1:0]                 own_node_reg;
    logic [dvru_pkg::NODE_COUNT-1:0] route_present_reg;
    logic [dvru_pkg::NODE_COUNT-1:0] link_present_reg;
    logic                            row_dirty_reg;
    logic [dvru_pkg::CNT_W-1:0]      cnt_reg;
    logic                            chk_vld_reg;
    logic [ID_W-1:0]                 chk_addr_reg;

    logic                            m_tvalid_reg;
    logic [31:0]                     m_tdata_reg;
    logic                            m_tuser_reg;

    logic                            accept;
    logic                            out_free;
    logic                            exec_go;
    logic                            sweep_rd;
    logic                            route_re;
    logic [ID_W-1:0]                 route_raddr;
    logic [dvru_pkg::ROUTE_W-1:0]    route_rdata;
    logic [dvru_pkg::DIST_BITS-1:0]  link_rdata;

    assign s_item.req_type     = s_tuser;
    assign s_item.neighbor_id  = s_tdata[5:0];
    assign s_item.dest_id      = s_tdata[11:6];
    assign s_item.link_cost    = s_tdata[28:12];
    assign s_item.adv_dist     = s_tdata[44:29];
    assign s_item.adv_next_hop = s_tdata[50:45];
    assign s_item.last_entry   = s_tlast;

    assign s_tready = (state_reg == dvru_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign exec_go  = (state_reg == dvru_pkg::ST_EXEC) && out_free;
    assign sweep_rd = (state_reg == dvru_pkg::ST_PURGE) &&
                      (cnt_reg < dvru_pkg::CNT_W'(dvru_pkg::NODE_COUNT));

    assign route_re    = accept || sweep_rd;
    assign route_raddr = sweep_rd ? cnt_reg[ID_W-1:0]
                       : (s_tuser == dvru_pkg::REQ_ADV) ? s_item.dest_id
                       : s_item.neighbor_id;

    dvru_ram #(
        .WIDTH (dvru_pkg::ROUTE_W),
        .DEPTH (dvru_pkg::NODE_COUNT)
    ) u_route_ram (
        .aclk  (aclk),
        .we    (exec_go && upd.route_we),
        .waddr ((item_reg.req_type == dvru_pkg::REQ_ADV) ? item_reg.dest_id
                                                         : item_reg.neighbor_id),
        .wdata ({upd.route_dist, upd.route_next_hop}),
        .re    (route_re),
        .raddr (route_raddr),
        .rdata (route_rdata)
    );

    dvru_ram #(
        .WIDTH (dvru_pkg::DIST_BITS),
        .DEPTH (dvru_pkg::NODE_COUNT)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (exec_go && upd.link_we),
        .waddr (item_reg.neighbor_id),
        .wdata (item_reg.link_cost[dvru_pkg::DIST_BITS-1:0]),
        .re    (accept),
        .raddr (s_item.neighbor_id),
        .rdata (link_rdata)
    );

    dvru_update u_update (
        .item        (item_reg),
        .own_node    (own_node_reg),
        .link_ok     (link_present_reg[item_reg.neighbor_id]),
        .link_weight (link_rdata),
        .cur_present (route_present_reg[item_reg.dest_id]),
        .cur_dist    (route_rdata[dvru_pkg::ROUTE_W-1:ID_W]),
        .cur_hop     (route_rdata[ID_W-1:0]),
        .row_dirty   (row_dirty_reg),
        .upd         (upd)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dvru_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = dvru_pkg::ST_EXEC;
                end
            end
            dvru_pkg::ST_EXEC: begin
                if (out_free) begin
                    state_next = upd.link_remove ? dvru_pkg::ST_PURGE : dvru_pkg::ST_IDLE;
                end
            end
            dvru_pkg::ST_PURGE: begin
                if (cnt_reg == dvru_pkg::CNT_W'(dvru_pkg::NODE_COUNT)) begin
                    state_next = dvru_pkg::ST_IDLE;
                end
            end
            default: state_next = dvru_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dvru_pkg::ST_IDLE;
            own_node_reg <= '0;
            row_dirty_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
            chk_vld_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                own_node_reg <= cfg_wdata;
            end
            if (exec_go) begin
                row_dirty_reg <= upd.row_dirty_next;
            end
            if (exec_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (exec_go) begin
                cnt_reg <= '0;
            end else if (sweep_rd) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            chk_vld_reg <= sweep_rd;
        end
    end

    // Valid bits: set on a route or link write, cleared by removal and sweep.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            route_present_reg <= '0;
            link_present_reg  <= '0;
        end else begin
            if (exec_go && upd.route_we) begin
                route_present_reg[(item_reg.req_type == dvru_pkg::REQ_ADV) ?
                                  item_reg.dest_id : item_reg.neighbor_id] <= 1'b1;
            end
            if (exec_go && upd.link_we) begin
                link_present_reg[item_reg.neighbor_id] <= 1'b1;
            end
            if (exec_go && upd.link_remove) begin
                link_present_reg[item_reg.neighbor_id]  <= 1'b0;
                route_present_reg[item_reg.neighbor_id] <= 1'b0;
            end
            if (chk_vld_reg && route_rdata[ID_W-1:0] == item_reg.neighbor_id) begin
                route_present_reg[chk_addr_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_item;
        end
        chk_addr_reg <= cnt_reg[ID_W-1:0];
        if (exec_go) begin
            m_tuser_reg <= upd.status;
            m_tdata_reg <= {7'b0, upd.row_changed, upd.route_next_hop, upd.route_dist,
                            upd.route_valid, upd.entry_changed};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> rtl/dvru_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered; no dependencies.
module dvru_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/dvru_update.sv
// Decision logic for one request: link update or advertisement entry.
// Works on the registered request and memory read data; uses dvru_pkg.
module dvru_update (
    input  dvru_pkg::item_t                 item,
    input  logic [dvru_pkg::ID_W-1:0]       own_node,
    input  logic                            link_ok,
    input  logic [dvru_pkg::DIST_BITS-1:0]  link_weight,
    input  logic                            cur_present,
    input  logic [dvru_pkg::DIST_BITS-1:0]  cur_dist,
    input  logic [dvru_pkg::ID_W-1:0]       cur_hop,
    input  logic                            row_dirty,
    output dvru_pkg::upd_t                  upd
);

    logic [dvru_pkg::COST_W-1:0]    sum_wide;
    logic [dvru_pkg::DIST_BITS-1:0] sum;
    logic                           neg;
    logic                           ch;

    assign sum_wide = {1'b0, link_weight} + {1'b0, item.adv_dist};
    assign sum      = sum_wide[dvru_pkg::DIST_BITS] ? dvru_pkg::DIST_MAX
                                                    : sum_wide[dvru_pkg::DIST_BITS-1:0];
    assign neg      = item.link_cost[dvru_pkg::COST_W-1];

    always_comb begin
        upd                = '0;
        upd.status         = dvru_pkg::STATUS_APPLIED;
        upd.row_dirty_next = row_dirty;
        ch                 = 1'b0;
        if (item.req_type == dvru_pkg::REQ_LINK) begin
            if (item.neighbor_id == own_node || (neg && !link_ok)) begin
                upd.status = dvru_pkg::STATUS_IGNORED;
            end else if (neg) begin
                // Removal reports an absent route; the sweep purges the rest.
                upd.entry_changed = 1'b1;
                upd.link_remove   = 1'b1;
            end else begin
                upd.entry_changed  = 1'b1;
                upd.link_we        = 1'b1;
                upd.route_we       = 1'b1;
                upd.route_valid    = 1'b1;
                upd.route_dist     = item.link_cost[dvru_pkg::DIST_BITS-1:0];
                upd.route_next_hop = item.neighbor_id;
            end
        end else begin
            if (item.neighbor_id == own_node || !link_ok) begin
                upd.status = dvru_pkg::STATUS_IGNORED;
            end else if (item.dest_id == own_node) begin
                upd.route_valid    = 1'b1;
                upd.route_next_hop = own_node;
            end else begin
                upd.route_valid = 1'b1;
                if (!cur_present) begin
                    ch = 1'b1;
                end else if (cur_hop == item.neighbor_id) begin
                    ch = (cur_dist != sum);
                end else if (item.adv_next_hop != own_node && sum < cur_dist) begin
                    ch = 1'b1;
                end
                if (ch || (cur_present && cur_hop == item.neighbor_id)) begin
                    upd.route_dist     = sum;
                    upd.route_next_hop = item.neighbor_id;
                end else begin
                    upd.route_dist     = cur_dist;
                    upd.route_next_hop = cur_hop;
                end
                upd.route_we      = ch;
                upd.entry_changed = ch;
            end
            if (item.last_entry) begin
                upd.row_changed    = row_dirty | ch;
                upd.row_dirty_next = 1'b0;
            end else begin
                upd.row_dirty_next = row_dirty | ch;
            end
        end
    end

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for distance_vector_route_update_top.
// Depends on dvru_pkg and the RTL top level; the routing table is predicted
// in the testbench itself and every result is checked in order.
module tb_top;

    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic                           status;
        logic                           entry_changed;
        logic                           route_valid;
        logic [dvru_pkg::DIST_BITS-1:0] route_dist;
        logic [dvru_pkg::ID_W-1:0]      route_next_hop;
        logic                           row_changed;
    } route_report_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [5:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    distance_vector_route_update_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Predicted routing table.
    logic [dvru_pkg::ID_W-1:0]      own_id;
    logic                           link_up   [dvru_pkg::NODE_COUNT];
    logic [dvru_pkg::DIST_BITS-1:0] link_len  [dvru_pkg::NODE_COUNT];
    logic                           route_ok  [dvru_pkg::NODE_COUNT];
    logic [dvru_pkg::DIST_BITS-1:0] route_len [dvru_pkg::NODE_COUNT];
    logic [dvru_pkg::ID_W-1:0]      route_via [dvru_pkg::NODE_COUNT];
    logic                           row_touched;

    dvru_pkg::item_t requests_pending[$];
    route_report_t   routes_expected[$];
    dvru_pkg::item_t req_on_bus;
    route_report_t   route_seen;
    route_report_t   route_wanted;
    int              requests_loaded = 0;
    int              requests_taken  = 0;
    int              src_idle_pct    = 0;
    int              sink_idle_pct   = 0;
    int              errors          = 0;
    int              quiet_cycles    = 0;

    initial forever #2 aclk = ~aclk;

    function automatic route_report_t route_to(logic [dvru_pkg::ID_W-1:0] d);
        route_report_t r;
        r = '0;
        if (d == own_id) begin
            r.route_valid    = 1'b1;
            r.route_next_hop = own_id;
        end else if (route_ok[d]) begin
            r.route_valid    = 1'b1;
            r.route_dist     = route_len[d];
            r.route_next_hop = route_via[d];
        end
        return r;
    endfunction

    function automatic route_report_t apply_request(dvru_pkg::item_t it);
        route_report_t                  r;
        logic [dvru_pkg::DIST_BITS:0]   path;
        logic [dvru_pkg::DIST_BITS-1:0] path_sat;
        logic [dvru_pkg::ID_W-1:0]      nb;
        logic [dvru_pkg::ID_W-1:0]      d;
        logic                           changed;
        r       = '0;
        changed = 1'b0;
        nb      = it.neighbor_id;
        d       = it.dest_id;
        if (it.req_type == dvru_pkg::REQ_LINK) begin
            if (nb == own_id || (it.link_cost[dvru_pkg::COST_W-1] && !link_up[nb])) begin
                r.status = dvru_pkg::STATUS_IGNORED;
            end else begin
                if (!it.link_cost[dvru_pkg::COST_W-1]) begin
                    link_up[nb]   = 1'b1;
                    link_len[nb]  = it.link_cost[dvru_pkg::DIST_BITS-1:0];
                    route_ok[nb]  = 1'b1;
                    route_len[nb] = it.link_cost[dvru_pkg::DIST_BITS-1:0];
                    route_via[nb] = nb;
                end else begin
                    // Dropping a link also drops every route that used it.
                    link_up[nb]  = 1'b0;
                    route_ok[nb] = 1'b0;
                    for (int i = 0; i < dvru_pkg::NODE_COUNT; i++)
                        if (route_ok[i] && route_via[i] == nb)
                            route_ok[i] = 1'b0;
                end
                r = route_to(nb);
                r.entry_changed = 1'b1;
            end
        end else begin
            if (nb == own_id || !link_up[nb]) begin
                r.status = dvru_pkg::STATUS_IGNORED;
            end else begin
                path     = {1'b0, link_len[nb]} + {1'b0, it.adv_dist};
                path_sat = path[dvru_pkg::DIST_BITS] ? dvru_pkg::DIST_MAX
                                                     : path[dvru_pkg::DIST_BITS-1:0];
                if (d != own_id) begin
                    if (!route_ok[d]) begin
                        route_ok[d]  = 1'b1;
                        route_len[d] = path_sat;
                        route_via[d] = nb;
                        changed      = 1'b1;
                    end else if (route_via[d] == nb) begin
                        if (route_len[d] != path_sat) begin
                            route_len[d] = path_sat;
                            changed      = 1'b1;
                        end
                    end else if (it.adv_next_hop == own_id) begin
                        // Poisoned reverse: the neighbor reaches d through us.
                    end else if (path_sat < route_len[d]) begin
                        route_len[d] = path_sat;
                        route_via[d] = nb;
                        changed      = 1'b1;
                    end
                end
                if (changed)
                    row_touched = 1'b1;
                r = route_to(d);
                r.entry_changed = changed;
            end
            if (it.last_entry) begin
                r.row_changed = row_touched;
                row_touched   = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic string show(route_report_t r);
        return $sformatf("status=%0d changed=%0d valid=%0d dist=%0d hop=%0d row=%0d",
                         r.status, r.entry_changed, r.route_valid, r.route_dist,
                         r.route_next_hop, r.row_changed);
    endfunction

    function automatic dvru_pkg::item_t link_req(logic [dvru_pkg::ID_W-1:0] nb,
                                                 logic signed [dvru_pkg::COST_W-1:0] cost);
        dvru_pkg::item_t it;
        it.req_type     = dvru_pkg::REQ_LINK;
        it.neighbor_id  = nb;
        it.dest_id      = dvru_pkg::ID_W'($urandom);
        it.link_cost    = cost;
        it.adv_dist     = dvru_pkg::DIST_BITS'($urandom);
        it.adv_next_hop = dvru_pkg::ID_W'($urandom);
        it.last_entry   = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic dvru_pkg::item_t adv_req(logic [dvru_pkg::ID_W-1:0] nb,
                                                logic [dvru_pkg::ID_W-1:0] d,
                                                logic [dvru_pkg::DIST_BITS-1:0] dist_val,
                                                logic [dvru_pkg::ID_W-1:0] nh,
                                                logic last);
        dvru_pkg::item_t it;
        it.req_type     = dvru_pkg::REQ_ADV;
        it.neighbor_id  = nb;
        it.dest_id      = d;
        it.link_cost    = dvru_pkg::COST_W'($urandom);
        it.adv_dist     = dist_val;
        it.adv_next_hop = nh;
        it.last_entry   = last;
        return it;
    endfunction

    task automatic send(dvru_pkg::item_t it);
        requests_pending.push_back(it);
        requests_loaded++;
    endtask

    task automatic write_own_node(logic [dvru_pkg::ID_W-1:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        own_id     = v;
    endtask

    // Waits until every request went through and every result came back, then
    // leaves room for a trailing purge sweep.
    task automatic wait_drained();
        while (requests_taken != requests_loaded || routes_expected.size() != 0)
            @(posedge aclk);
        repeat (dvru_pkg::NODE_COUNT + 8) @(posedge aclk);
    endtask

    // Runs with own_node = 10.
    task automatic load_directed();
        send(link_req(6'd0, 17'sd5));
        send(link_req(6'd63, 17'sd65535));
        send(link_req(6'd10, 17'sd3));
        send(link_req(6'd20, -17'sd1));
        send(link_req(6'd1, 17'sd1));
        send(link_req(6'd2, 17'sd0));
        send(adv_req(6'd20, 6'd30, 16'd4, 6'd0, 1'b0));
        send(adv_req(6'd0, 6'd30, 16'd7, 6'd1, 1'b0));
        send(adv_req(6'd0, 6'd10, 16'd3, 6'd0, 1'b0));
        send(adv_req(6'd1, 6'd30, 16'd2, 6'd10, 1'b0));
        send(adv_req(6'd1, 6'd30, 16'd2, 6'd5, 1'b0));
        send(adv_req(6'd1, 6'd30, 16'd9, 6'd5, 1'b0));
        send(adv_req(6'd0, 6'd40, 16'hFFFF, 6'd0, 1'b0));
        send(adv_req(6'd63, 6'd41, 16'd1, 6'd63, 1'b0));
        send(adv_req(6'd1, 6'd41, 16'd0, 6'd0, 1'b1));
        send(adv_req(6'd0, 6'd63, 16'd100, 6'd63, 1'b1));
        send(adv_req(6'd20, 6'd0, 16'd1, 6'd0, 1'b1));
        send(link_req(6'd0, 17'sd8));
        send(link_req(6'd1, -17'sd1));
        send(adv_req(6'd0, 6'd30, 16'd2, 6'd3, 1'b0));
        send(link_req(6'd63, 17'h10000));
        send(adv_req(6'd0, 6'd30, 16'd2, 6'd3, 1'b1));
        send(adv_req(6'd0, 6'd5, 16'hFFFE, 6'd63, 1'b1));
        send(adv_req(6'd2, 6'd63, 16'd0, 6'd10, 1'b1));
    endtask

    // Mostly well-formed rows from a small set of neighbors, with link changes,
    // link removals and some fully random requests mixed in.
    task automatic load_random(int n);
        logic [dvru_pkg::ID_W-1:0]          pool [6];
        logic [dvru_pkg::ID_W-1:0]          nb;
        logic [dvru_pkg::ID_W-1:0]          d;
        logic [dvru_pkg::ID_W-1:0]          nh;
        logic [dvru_pkg::DIST_BITS-1:0]     dist_val;
        logic signed [dvru_pkg::COST_W-1:0] cost;
        dvru_pkg::item_t                    junk;
        int                                 made;
        int                                 roll;
        int                                 len;
        foreach (pool[k])
            pool[k] = dvru_pkg::ID_W'($urandom_range(dvru_pkg::NODE_COUNT - 1));
        made = 0;
        while (made < n) begin
            roll = $urandom_range(99);
            nb   = pool[$urandom_range(5)];
            if (roll < 12) begin
                case ($urandom_range(9))
                    0:       cost = '0;
                    1, 2:    cost = {1'b0, 16'($urandom)};
                    default: cost = dvru_pkg::COST_W'($urandom_range(1, 300));
                endcase
                send(link_req(nb, cost));
                made++;
            end else if (roll < 16) begin
                send(link_req(nb, {1'b1, 16'($urandom)}));
                made++;
            end else if (roll < 88) begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(1))
                        d = pool[$urandom_range(5)];
                    else
                        d = dvru_pkg::ID_W'($urandom_range(dvru_pkg::NODE_COUNT - 1));
                    case ($urandom_range(6))
                        0:       dist_val = dvru_pkg::DIST_MAX;
                        1:       dist_val = dvru_pkg::DIST_BITS'($urandom);
                        default: dist_val = dvru_pkg::DIST_BITS'($urandom_range(0, 400));
                    endcase
                    nh = ($urandom_range(3) == 0) ? own_id : 6'($urandom);
                    send(adv_req(nb, d, dist_val, nh, k == len - 1));
                end
                made += len;
            end else begin
                junk.req_type     = 1'($urandom_range(1));
                junk.neighbor_id  = dvru_pkg::ID_W'($urandom);
                junk.dest_id      = dvru_pkg::ID_W'($urandom);
                junk.link_cost    = dvru_pkg::COST_W'($urandom);
                junk.adv_dist     = dvru_pkg::DIST_BITS'($urandom);
                junk.adv_next_hop = dvru_pkg::ID_W'($urandom);
                junk.last_entry   = 1'($urandom_range(1));
                send(junk);
                made++;
            end
        end
    endtask

    // Request driver.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                routes_expected.push_back(apply_request(req_on_bus));
                requests_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (requests_pending.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    req_on_bus = requests_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'b0, req_on_bus.adv_next_hop, req_on_bus.adv_dist,
                                 req_on_bus.link_cost, req_on_bus.dest_id,
                                 req_on_bus.neighbor_id};
                    s_tuser  <= req_on_bus.req_type;
                    s_tlast  <= req_on_bus.last_entry;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                route_seen = {m_tuser, m_tdata[0], m_tdata[1], m_tdata[17:2],
                              m_tdata[23:18], m_tdata[24]};
                if (routes_expected.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected: %s", $time, show(route_seen));
                end else begin
                    route_wanted = routes_expected.pop_front();
                    if (route_seen !== route_wanted) begin
                        errors++;
                        $display("%0t: mismatch expected %s", $time, show(route_wanted));
                        $display("%0t:          actual   %s", $time, show(route_seen));
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < dvru_pkg::NODE_COUNT; i++) begin
            link_up[i]   = 1'b0;
            link_len[i]  = '0;
            route_ok[i]  = 1'b0;
            route_len[i] = '0;
            route_via[i] = '0;
        end
        own_id      = '0;
        row_touched = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        src_idle_pct  = 35;
        sink_idle_pct = 47;
        write_own_node(6'd10);
        load_directed();
        wait_drained();

        write_own_node(6'd63);
        load_random(500);
        wait_drained();

        src_idle_pct  = 47;
        sink_idle_pct = 35;
        write_own_node(6'd0);
        load_random(500);
        wait_drained();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_own_node(dvru_pkg::ID_W'($urandom_range(1, dvru_pkg::NODE_COUNT - 2)));
        load_random(500);
        wait_drained();

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
